### rtl/arro_pkg.sv
// Package for the activation range reservoir observer.
// Holds constants, the sequencer state type and the format codes.
`default_nettype none
package arro_pkg;
    localparam int unsigned RESERVOIR_DEPTH_DEF = 2048;
    localparam logic [63:0] LCG_MUL  = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD  = 64'd1442695040888963407;
    localparam logic [63:0] LCG_SEED = 64'h9e3779b97f4a7c15;
    localparam logic [31:0] POS_INF_BITS = 32'h7f800000;
    localparam logic [31:0] LOWEST_BITS  = 32'hff7fffff;

    localparam logic [1:0] FMT_FP32 = 2'd0;
    localparam logic [1:0] FMT_FP16 = 2'd1;
    localparam logic [1:0] FMT_BF16 = 2'd2;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_READ    = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] value_bits;
        logic [10:0] read_index;
    } arro_in_t;

    typedef struct packed {
        logic [31:0] minimum_bits;
        logic [31:0] maximum_bits;
        logic        seen_any;
        logic [63:0] count_total;
        logic        accepted;
        logic        stored;
        logic [10:0] slot_index;
        logic [31:0] read_data;
        logic        read_valid;
    } arro_out_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_WRITE = 7'b0001000,
        ST_RDWT  = 7'b0010000,
        ST_RDOUT = 7'b0100000,
        ST_OUT   = 7'b1000000
    } arro_state_t;

    // Widen a sample to fp32; the flag is low for non-finite or unused formats.
    function automatic logic [32:0] arro_widen(input logic [1:0] fmt, input logic [31:0] raw);
        logic [31:0] f;
        logic        ok;
        logic [4:0]  ex;
        logic [9:0]  fr;
        logic [3:0]  p;
        logic [22:0] sh;
        f  = 32'd0;
        ok = 1'b1;
        ex = raw[14:10];
        fr = raw[9:0];
        p  = 4'd0;
        sh = 23'd0;
        unique case (fmt)
            FMT_FP32: f = raw;
            FMT_FP16:
            begin
                if (ex == 5'd0)
                begin
                    for (int i = 0; i < 10; i++)
                        if (fr[i])
                            p = 4'(i);
                    sh = {13'd0, fr} << (5'd23 - {1'b0, p});
                    if (fr == 10'd0)
                        f = {raw[15], 31'd0};
                    else
                        f = {raw[15], 8'({4'd0, p} + 8'd103), sh};
                end
                else if (ex == 5'h1f)
                    f = {raw[15], 8'hff, fr, 13'd0};
                else
                    f = {raw[15], 8'({3'd0, ex} + 8'd112), fr, 13'd0};
            end
            FMT_BF16: f = {raw[15:0], 16'd0};
            default:
            begin
                f  = 32'd0;
                ok = 1'b0;
            end
        endcase
        if ((f & POS_INF_BITS) == POS_INF_BITS)
            ok = 1'b0;
        return {ok, f};
    endfunction

    // True when a orders strictly below b; both zeros are equal.
    function automatic logic arro_less(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] ka;
        logic signed [32:0] kb;
        ka = a[31] ? -$signed({2'b00, a[30:0]}) : $signed({2'b00, a[30:0]});
        kb = b[31] ? -$signed({2'b00, b[30:0]}) : $signed({2'b00, b[30:0]});
        return ka < kb;
    endfunction
endpackage
`default_nettype wire

### rtl/arro_if.sv
// Valid/ready channel interface carrying a payload of a given type.
// No dependencies; the payload type is given as a parameter.
`default_nettype none
interface arro_if #(parameter type T = logic) (input wire logic clk);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/arro_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module arro_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  wire logic [WIDTH-1:0]                            wdata,
    output logic      [WIDTH-1:0]                            rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

### rtl/activation_range_reservoir_observer.sv
// Observe item: while the reservoir fills, the sample goes to write, then output;
// a non-finite one goes straight to output. Once full, shift-add steps and an increment
// make the LCG step, restoring-divide steps give the modulo, and a fitting slot is written.
// Read item: a wait and a read-out state through the reservoir RAM's registered read port.
// Output stalls hold the result. Reset (rst_n, async, active low) restores
// min/max, count, LCG seed and format; reservoir contents stay undefined until written.
`default_nettype none
module activation_range_reservoir_observer
    import arro_pkg::*;
#(
    parameter int unsigned RESERVOIR_DEPTH = RESERVOIR_DEPTH_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata,
    arro_if.sink            in_ch,
    arro_if.source          out_ch
);
    localparam int unsigned AW = (RESERVOIR_DEPTH > 1) ? $clog2(RESERVOIR_DEPTH) : 1;
    localparam logic [64:0] DEPTH65 = 65'(RESERVOIR_DEPTH);

    arro_state_t state_reg, state_next;
    logic [1:0]  fmt_reg;
    logic [31:0] min_reg, max_reg;
    logic        seen_reg;
    logic [63:0] total_reg, lcg_reg;
    logic [63:0] acc_reg;      // product, then dividend shift register
    logic [63:0] rem_reg;
    logic [63:0] mcand_reg;
    logic [6:0]  cnt_reg;
    logic [31:0] f_reg;
    logic [10:0] ridx_reg;
    logic [AW-1:0] slot_reg;
    logic        store_reg;
    logic        taken_reg;
    logic [31:0] rdata_reg;
    logic        rvalid_reg;
    arro_out_t   res;
    logic        we;
    logic [AW-1:0] addr;
    logic [31:0] rdata;
    logic [32:0] wide;
    logic [64:0] trial;
    logic [63:0] rem_step;
    logic        rem_fits;

    assign wide = arro_widen(fmt_reg, in_ch.data.value_bits);

    arro_ram #(.WIDTH(32), .DEPTH(RESERVOIR_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (f_reg),
        .rdata (rdata)
    );

    assign trial    = {rem_reg, acc_reg[63]} - {1'b0, total_reg};
    assign rem_step = trial[64] ? {rem_reg[62:0], acc_reg[63]} : trial[63:0];
    assign rem_fits = {1'b0, rem_step} < DEPTH65;

    assign in_ch.ready  = (state_reg == ST_IDLE) && !out_ch.valid;
    assign out_ch.valid = (state_reg == ST_OUT);

    // The running state does not move while a result waits, so it is read directly.
    always_comb
    begin
        res.minimum_bits = min_reg;
        res.maximum_bits = max_reg;
        res.seen_any     = seen_reg;
        res.count_total  = total_reg;
        res.accepted     = taken_reg;
        res.stored       = store_reg;
        res.slot_index   = store_reg ? 11'(slot_reg) : 11'd0;
        res.read_data    = rdata_reg;
        res.read_valid   = rvalid_reg;
    end
    assign out_ch.data = res;

    always_comb
    begin
        we   = (state_reg == ST_WRITE);
        addr = (state_reg == ST_WRITE) ? slot_reg : AW'(ridx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fmt_reg   <= FMT_FP32;
            min_reg   <= POS_INF_BITS;
            max_reg   <= LOWEST_BITS;
            seen_reg  <= 1'b0;
            total_reg <= 64'd0;
            lcg_reg   <= LCG_SEED;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                fmt_reg <= cfg_wdata;
            if (state_reg == ST_MUL && cnt_reg == 7'd64)
                lcg_reg <= acc_reg + LCG_ADD;
            if (state_reg == ST_IDLE && in_ch.valid && in_ch.ready
                && in_ch.data.opcode == OP_OBSERVE && wide[32])
            begin
                if (arro_less(wide[31:0], min_reg))
                    min_reg <= wide[31:0];
                if (arro_less(max_reg, wide[31:0]))
                    max_reg <= wide[31:0];
                seen_reg <= 1'b1;
                if (total_reg != '1)
                    total_reg <= total_reg + 64'd1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_ch.valid && in_ch.ready)
                begin
                    if (in_ch.data.opcode == OP_READ)
                        state_next = ST_RDWT;
                    else if (!wide[32])
                        state_next = ST_OUT;
                    else if ({1'b0, total_reg} < DEPTH65)
                        state_next = ST_WRITE;
                    else
                        state_next = ST_MUL;
                end
            ST_MUL:   if (cnt_reg == 7'd64) state_next = ST_DIV;
            ST_DIV:
                if (cnt_reg == 7'd63)
                    state_next = rem_fits ? ST_WRITE : ST_OUT;
            ST_WRITE: state_next = ST_OUT;
            ST_RDWT:  state_next = ST_RDOUT;
            ST_RDOUT: state_next = ST_OUT;
            ST_OUT:   if (out_ch.ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Datapath: operands load in idle; then one shift-add or one subtract step per cycle, and read data is captured.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                f_reg      <= wide[31:0];
                ridx_reg   <= in_ch.data.read_index;
                cnt_reg    <= 7'd0;
                acc_reg    <= 64'd0;
                mcand_reg  <= lcg_reg;
                slot_reg   <= AW'(total_reg);
                store_reg  <= in_ch.data.opcode == OP_OBSERVE && wide[32]
                              && ({1'b0, total_reg} < DEPTH65);
                taken_reg  <= in_ch.data.opcode == OP_OBSERVE && wide[32];
                rdata_reg  <= 32'd0;
                rvalid_reg <= 1'b0;
            end
            ST_MUL:
            begin
                if (cnt_reg != 7'd64)
                begin
                    if (LCG_MUL[6'(cnt_reg)])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg <= mcand_reg << 1;
                    cnt_reg   <= cnt_reg + 7'd1;
                end
                else
                begin
                    acc_reg <= acc_reg + LCG_ADD;
                    rem_reg <= 64'd0;
                    cnt_reg <= 7'd0;
                end
            end
            ST_DIV:
            begin
                acc_reg <= acc_reg << 1;
                cnt_reg <= cnt_reg + 7'd1;
                rem_reg <= rem_step;
                if (cnt_reg == 7'd63)
                begin
                    slot_reg  <= AW'(rem_step);
                    store_reg <= rem_fits;
                end
            end
            ST_RDOUT:
            begin
                if ({53'd0, ridx_reg} < total_reg && {54'd0, ridx_reg} < DEPTH65)
                begin
                    rdata_reg  <= rdata;
                    rvalid_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_store_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.stored |-> out_ch.data.accepted)
        else $error("stored without accepted");
    a_read_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.data.read_valid |-> !out_ch.data.accepted)
        else $error("read and observe flags together");
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg != $past(total_reg) |-> $past(state_reg) == ST_IDLE)
        else $error("count changed outside accept");
`endif
endmodule
`default_nettype wire
